### sv/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg: types and constants for the spin rotation pipeline
// Payload structs, fixed-point constants and small helpers.
// ----------------------------------------------------------------------------
package srr_pkg;

	typedef struct packed {
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] spin_in_x;
		logic signed [31:0] spin_in_y;
		logic signed [31:0] spin_in_z;
		logic               last_spin;
	} in_t;

	typedef struct packed {
		logic signed [31:0] spin_out_x;
		logic signed [31:0] spin_out_y;
		logic signed [31:0] spin_out_z;
		logic               last_out;
	} out_t;

	localparam logic [63:0] HALF_PI_Q59 = 64'h0C90FDAA22168C23;
	localparam logic [31:0] QONE        = 32'h4000_0000;

	// Stage counts of the iterative cell rows
	localparam int SQRT_STEPS = 32;   // one result bit per cell
	localparam int DIV_STEPS  = 31;   // quotient bits of the unit vector
	localparam int RED_STEPS  = 5;    // angle reduction: k has at most 5 bits
	localparam int POLY_STEPS = 6;    // Horner terms

	// Reciprocals ceil(2^s / d) with s = 30 + ceil(log2 d): exact floor
	// division for every dividend below 2^30
	localparam logic [31:0] RCP_156 = 32'(((64'd1 << 38) + 64'd155) / 64'd156);
	localparam logic [31:0] RCP_110 = 32'(((64'd1 << 37) + 64'd109) / 64'd110);
	localparam logic [31:0] RCP_72  = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
	localparam logic [31:0] RCP_42  = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
	localparam logic [31:0] RCP_20  = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
	localparam logic [31:0] RCP_6   = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
	localparam logic [31:0] RCP_132 = 32'(((64'd1 << 38) + 64'd131) / 64'd132);
	localparam logic [31:0] RCP_90  = 32'(((64'd1 << 37) + 64'd89) / 64'd90);
	localparam logic [31:0] RCP_56  = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
	localparam logic [31:0] RCP_30  = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
	localparam logic [31:0] RCP_12  = 32'(((64'd1 << 34) + 64'd11) / 64'd12);
	localparam logic [31:0] RCP_2   = 32'(((64'd1 << 31) + 64'd1) / 64'd2);

	// Horner divisors for sine (156,110,72,42,20,6), one per cell
	function automatic logic [31:0] sin_rcp(input int i);
		unique case (i)
			0: sin_rcp = RCP_156;
			1: sin_rcp = RCP_110;
			2: sin_rcp = RCP_72;
			3: sin_rcp = RCP_42;
			4: sin_rcp = RCP_20;
			default: sin_rcp = RCP_6;
		endcase
	endfunction

	function automatic int sin_sh(input int i);
		unique case (i)
			0: sin_sh = 38;
			1: sin_sh = 37;
			2: sin_sh = 37;
			3: sin_sh = 36;
			4: sin_sh = 35;
			default: sin_sh = 33;
		endcase
	endfunction

	// Horner divisors for cosine (132,90,56,30,12,2)
	function automatic logic [31:0] cos_rcp(input int i);
		unique case (i)
			0: cos_rcp = RCP_132;
			1: cos_rcp = RCP_90;
			2: cos_rcp = RCP_56;
			3: cos_rcp = RCP_30;
			4: cos_rcp = RCP_12;
			default: cos_rcp = RCP_2;
		endcase
	endfunction

	function automatic int cos_sh(input int i);
		unique case (i)
			0: cos_sh = 38;
			1: cos_sh = 37;
			2: cos_sh = 36;
			3: cos_sh = 35;
			4: cos_sh = 34;
			default: cos_sh = 31;
		endcase
	endfunction

	// Signed Q.30 product, truncated toward zero; operands fit in 34 bits
	function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [33:0] an;
		logic signed [33:0] bn;
		logic signed [67:0] p;
		logic [67:0]        m;
		an = a[33:0];
		bn = b[33:0];
		p = an * bn;
		m = p[67] ? (~p + 68'd1) : p;
		m = m >> 30;
		mulq = p[67] ? -$signed(m[63:0]) : $signed(m[63:0]);
	endfunction

endpackage

### sv/spin_rodrigues_rotation.sv
// ----------------------------------------------------------------------------
// spin_rodrigues_rotation: rotate a spin by a rotation vector
// Fixed-point Rodrigues rotation built as a chain of pipeline cells.
// ----------------------------------------------------------------------------
// The result passes through 83 chain cells for sqrt, divide, angle reduction and polynomial,
// then through 4 matrix stages before it is strobed.
// Throughput: one transaction per cycle; busy is always low.
// Reset clears every valid bit of the chain; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module spin_rodrigues_rotation (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  srr_pkg::in_t    in_data,
	output logic            strobe,
	output srr_pkg::out_t   out_data
);

	localparam int NSQ = srr_pkg::SQRT_STEPS;
	localparam int NDV = srr_pkg::DIV_STEPS;
	localparam int NRD = srr_pkg::RED_STEPS;
	localparam int NPL = srr_pkg::POLY_STEPS;

	// Working record carried down the chain
	typedef struct packed {
		srr_pkg::in_t  it;
		logic          zero;
		logic [63:0]   op;      // sqrt remainder / angle remainder
		logic [63:0]   res;     // sqrt root bits
		logic [31:0]   theta;
		logic [62:0]   rx, ry, rz;   // division remainders
		logic [30:0]   qx, qy, qz;   // quotient bits
		logic [4:0]    k;
		logic          fold;
		logic [31:0]   w;
		logic [31:0]   w2;
		logic [31:0]   ts, tc;
		logic [31:0]   ps, pc;       // Horner products awaiting division
	} work_t;

	localparam int WW = $bits(work_t);
	localparam int P0 = NSQ + 1 + NDV + NRD + 1;   // first polynomial cell
	localparam int NC = P0 + 2 * NPL + 1;

	work_t cell_d [NC];
	work_t cell_q [NC];
	logic  vin    [NC];
	logic  vout   [NC];

	assign busy = 1'b0;

	// Next-value function of each cell, selected by its position
	function automatic work_t step(input int n, input work_t a);
		work_t       b;
		int          sb;
		int          hn;
		logic [63:0] bitv;
		logic [63:0] tr;
		logic [63:0] hs;
		logic [63:0] u;
		logic [63:0] pr;
		b = a;
		if (n < NSQ) begin
			// Restoring square root, one result bit per cell
			sb = NSQ - 1 - n;
			bitv = 64'd1 << (2 * sb);
			if (a.op >= a.res + bitv) begin
				b.op  = a.op - (a.res + bitv);
				b.res = (a.res >> 1) + bitv;
			end else begin
				b.res = a.res >> 1;
			end
		end else if (n == NSQ) begin
			b.theta = a.res[31:0];
			// |d| <= theta: the remainder starts at |d|
			tr = {32'd0, (a.it.dir_x[31] ? -a.it.dir_x : a.it.dir_x)};
			b.rx = tr[62:0];
			tr = {32'd0, (a.it.dir_y[31] ? -a.it.dir_y : a.it.dir_y)};
			b.ry = tr[62:0];
			tr = {32'd0, (a.it.dir_z[31] ? -a.it.dir_z : a.it.dir_z)};
			b.rz = tr[62:0];
			b.qx = 31'd0;
			b.qy = 31'd0;
			b.qz = 31'd0;
		end else if (n < NSQ + 1 + NDV) begin
			// Long division of |d|<<30 by theta, one quotient bit per cell
			sb = NSQ + NDV - n;
			b.rx = (sb == NDV - 1) ? a.rx : {a.rx[61:0], 1'b0};
			if (b.rx >= {31'd0, a.theta}) begin
				b.rx = b.rx - {31'd0, a.theta};
				b.qx[sb] = 1'b1;
			end
			b.ry = (sb == NDV - 1) ? a.ry : {a.ry[61:0], 1'b0};
			if (b.ry >= {31'd0, a.theta}) begin
				b.ry = b.ry - {31'd0, a.theta};
				b.qy[sb] = 1'b1;
			end
			b.rz = (sb == NDV - 1) ? a.rz : {a.rz[61:0], 1'b0};
			if (b.rz >= {31'd0, a.theta}) begin
				b.rz = b.rz - {31'd0, a.theta};
				b.qz[sb] = 1'b1;
			end
			if (n == NSQ + NDV) begin
				b.op = {a.theta, 32'd0};
				b.k  = 5'd0;
			end
		end else if (n < NSQ + 1 + NDV + NRD) begin
			// Angle reduction: one quotient bit of T / (pi/2) per cell
			sb = NSQ + NDV + NRD - n;
			hs = srr_pkg::HALF_PI_Q59 << sb;
			if (a.op >= hs) begin
				b.op = a.op - hs;
				b.k[sb] = 1'b1;
			end
		end else if (n == NSQ + 1 + NDV + NRD) begin
			b.fold = ({a.op, 1'b0} > {1'b0, srr_pkg::HALF_PI_Q59});
			u = b.fold ? srr_pkg::HALF_PI_Q59 - a.op : a.op;
			u = (u + 64'h1000_0000) >> 29;
			b.w = u[31:0];
			pr = {32'd0, u[31:0]} * {32'd0, u[31:0]};
			b.w2 = pr[61:30];
			b.ts = srr_pkg::QONE;
			b.tc = srr_pkg::QONE;
		end else if (n < NC - 1) begin
			// Horner step for sine and cosine in parallel: a product cell,
			// then a cell dividing by the term's constant
			hn = n - P0;
			sb = hn >>> 1;
			if (hn[0] == 1'b0) begin
				pr = {32'd0, a.w2} * {32'd0, a.ts};
				b.ps = pr[61:30];
				pr = {32'd0, a.w2} * {32'd0, a.tc};
				b.pc = pr[61:30];
			end else begin
				pr = ({32'd0, a.ps} * {32'd0, srr_pkg::sin_rcp(sb)}) >>
					srr_pkg::sin_sh(sb);
				b.ts = srr_pkg::QONE - pr[31:0];
				pr = ({32'd0, a.pc} * {32'd0, srr_pkg::cos_rcp(sb)}) >>
					srr_pkg::cos_sh(sb);
				b.tc = srr_pkg::QONE - pr[31:0];
			end
		end else begin
			pr = {32'd0, a.w} * {32'd0, a.ts};
			b.ts = pr[61:30];
		end
		return b;
	endfunction

	work_t head;
	logic [63:0] ax, ay, az;

	always_comb begin
		head = '0;
		head.it = in_data;
		head.zero = (in_data.dir_x == 0) && (in_data.dir_y == 0) &&
			(in_data.dir_z == 0);
		ax = {32'd0, (in_data.dir_x[31] ? -in_data.dir_x : in_data.dir_x)};
		ay = {32'd0, (in_data.dir_y[31] ? -in_data.dir_y : in_data.dir_y)};
		az = {32'd0, (in_data.dir_z[31] ? -in_data.dir_z : in_data.dir_z)};
		head.op = ax * ax + ay * ay + az * az;
		head.res = 64'd0;
	end

	for (genvar g = 0; g < NC; g++) begin : g_cell
		if (g == 0) begin : g_h
			assign vin[g] = start;
			assign cell_d[g] = step(g, head);
		end else begin : g_n
			assign vin[g] = vout[g-1];
			assign cell_d[g] = step(g, cell_q[g-1]);
		end
		srr_item_cell #(.W(WW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (vin[g]),
			.dat    (cell_d[g]),
			.vld_s1 (vout[g]),
			.dat_s1 (cell_q[g])
		);
	end

	// Matrix stages
	work_t e;
	logic signed [63:0] s, c, A, B, D, x, y, z;
	assign e = cell_q[NC-1];

	always_comb begin
		s = e.fold ? $signed({32'd0, e.tc}) : $signed({32'd0, e.ts});
		c = e.fold ? $signed({32'd0, e.ts}) : $signed({32'd0, e.tc});
		unique case (e.k[1:0])
			2'd0: begin B = s;  A = c;  end
			2'd1: begin B = c;  A = -s; end
			2'd2: begin B = -s; A = -c; end
			default: begin B = -c; A = s; end
		endcase
		D = 64'sd1073741824 - A;
		x = e.it.dir_x[31] ? -$signed({33'd0, e.qx}) : $signed({33'd0, e.qx});
		y = e.it.dir_y[31] ? -$signed({33'd0, e.qy}) : $signed({33'd0, e.qy});
		z = e.it.dir_z[31] ? -$signed({33'd0, e.qz}) : $signed({33'd0, e.qz});
	end

	// stage m1: pair products
	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [63:0] A_s1, B_s1, D_s1, x_s1, y_s1, z_s1;
	logic signed [63:0] zz_s1, yy_s1, xx_s1, yz_s1, xz_s1, xy_s1;
	srr_pkg::in_t       it_s1, it_s2, it_s3, it_s4;
	logic               zero_s1, zero_s2, zero_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= vout[NC-1];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		A_s1 <= A;
		B_s1 <= B;
		D_s1 <= D;
		zz_s1 <= srr_pkg::mulq(z, z);
		yy_s1 <= srr_pkg::mulq(y, y);
		xx_s1 <= srr_pkg::mulq(x, x);
		yz_s1 <= srr_pkg::mulq(y, z);
		xz_s1 <= srr_pkg::mulq(x, z);
		xy_s1 <= srr_pkg::mulq(x, y);
		x_s1 <= x;
		y_s1 <= y;
		z_s1 <= z;
		it_s1 <= e.it;
		zero_s1 <= e.zero;
	end

	// stage m2: matrix entries
	logic signed [63:0] m_s2 [9];
	always_ff @(posedge clk) begin
		m_s2[0] <= A_s1 + srr_pkg::mulq(zz_s1, D_s1);
		m_s2[4] <= A_s1 + srr_pkg::mulq(yy_s1, D_s1);
		m_s2[8] <= A_s1 + srr_pkg::mulq(xx_s1, D_s1);
		m_s2[1] <= -srr_pkg::mulq(yz_s1, D_s1) + srr_pkg::mulq(x_s1, B_s1);
		m_s2[3] <= -srr_pkg::mulq(yz_s1, D_s1) - srr_pkg::mulq(x_s1, B_s1);
		m_s2[2] <= srr_pkg::mulq(xz_s1, D_s1) + srr_pkg::mulq(y_s1, B_s1);
		m_s2[6] <= srr_pkg::mulq(xz_s1, D_s1) - srr_pkg::mulq(y_s1, B_s1);
		m_s2[5] <= -srr_pkg::mulq(xy_s1, D_s1) + srr_pkg::mulq(z_s1, B_s1);
		m_s2[7] <= -srr_pkg::mulq(xy_s1, D_s1) - srr_pkg::mulq(z_s1, B_s1);
		it_s2 <= it_s1;
		zero_s2 <= zero_s1;
	end

	// stage m3: products with the spin, scaled by 1/256 toward zero
	logic signed [63:0] p_s3 [9];
	logic signed [31:0] vv [3];
	assign vv[0] = it_s2.spin_in_x;
	assign vv[1] = it_s2.spin_in_y;
	assign vv[2] = it_s2.spin_in_z;

	// matrix entries stay within 34 signed bits
	for (genvar j = 0; j < 9; j++) begin : g_p
		logic signed [65:0] pp;
		logic signed [65:0] ps;
		assign pp = $signed(m_s2[j][33:0]) * vv[j / 3];
		assign ps = (pp < 0) ? -((-pp) >>> 8) : (pp >>> 8);
		always_ff @(posedge clk) begin
			p_s3[j] <= ps[63:0];
		end
	end

	always_ff @(posedge clk) begin
		it_s3 <= it_s2;
		zero_s3 <= zero_s2;
	end

	function automatic logic signed [31:0] fin(input logic signed [63:0] acc);
		logic signed [63:0] q;
		q = (acc < 0) ? -((-acc) >>> 22) : (acc >>> 22);
		if (q > 64'sd2147483647) fin = 32'h7FFF_FFFF;
		else if (q < -64'sd2147483648) fin = 32'h8000_0000;
		else fin = q[31:0];
	endfunction

	srr_pkg::out_t o_s4;
	always_ff @(posedge clk) begin
		it_s4 <= it_s3;
		o_s4.spin_out_x <= zero_s3 ? it_s3.spin_in_x :
			fin(p_s3[0] + p_s3[3] + p_s3[6]);
		o_s4.spin_out_y <= zero_s3 ? it_s3.spin_in_y :
			fin(p_s3[1] + p_s3[4] + p_s3[7]);
		o_s4.spin_out_z <= zero_s3 ? it_s3.spin_in_z :
			fin(p_s3[2] + p_s3[5] + p_s3[8]);
		o_s4.last_out <= it_s3.last_spin;
	end

	assign strobe = v_s4;
	assign out_data = o_s4;

	a_busy: assert property (@(posedge clk) !busy)
		else $error("busy raised");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		vout[NC-1] |-> ##4 strobe)
		else $error("lost transaction");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> out_data.last_out == it_s4.last_spin)
		else $error("last flag mismatch");

endmodule

### sv/srr_item_cell.sv
// ----------------------------------------------------------------------------
// srr_item_cell: one stage of the rotation chain
// Holds one transaction's working values and hands them on every cycle.
// ----------------------------------------------------------------------------
module srr_item_cell #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vld,
	input  logic [W-1:0] dat,
	output logic         vld_s1,
	output logic [W-1:0] dat_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		dat_s1 <= dat;
	end

endmodule

### verif/tb_spin_rodrigues_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spin_rodrigues_rotation: self-checking bench for the spin rotation block
// Drives directed cases, then rotation vectors and spins in random bursts, predicts each rotated
// spin in fixed point and compares every strobed result in order.
// ----------------------------------------------------------------------------

class spin_scoreboard;
	srr_pkg::out_t rotated_q[$];
	int unsigned   n_errors;

	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned HALF_PI = 64'h0C90FDAA22168C23;

	function new();
		n_errors = 0;
	endfunction

	static function longint qmul(longint a, longint b);
		return (a * b) / longint'(ONE_Q30);
	endfunction

	static function longint unsigned int_sqrt(longint unsigned op);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > op) bitv >>= 2;
		while (bitv != 0) begin
			if (op >= res + bitv) begin
				op -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	static function longint unit_part(longint d, longint unsigned theta);
		longint unsigned mg, q;
		mg = (d < 0) ? 64'd0 - longint'(d) : d;
		q = (mg << 30) / theta;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	static function logic [31:0] clamp32(longint v);
		if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
		if (v < -64'sh80000000) v = -64'sh80000000;
		return v[31:0];
	endfunction

	static function srr_pkg::out_t rotate_spin(srr_pkg::in_t it);
		srr_pkg::out_t o;
		longint d[3], v[3], m[9];
		longint x, y, z, ca, sb, dd, s, c, tmp, s1, s2, s3, a1, a2, a3, acc;
		longint unsigned sq, theta, tq, k, r, w, w2, t, mg;
		longint unsigned sdv[6], cdv[6];
		bit fold;
		sdv = '{156, 110, 72, 42, 20, 6};
		cdv = '{132, 90, 56, 30, 12, 2};
		d[0] = it.dir_x; d[1] = it.dir_y; d[2] = it.dir_z;
		v[0] = it.spin_in_x; v[1] = it.spin_in_y; v[2] = it.spin_in_z;
		o.last_out = it.last_spin;
		if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
			o.spin_out_x = it.spin_in_x;
			o.spin_out_y = it.spin_in_y;
			o.spin_out_z = it.spin_in_z;
			return o;
		end
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			mg = (d[i] < 0) ? 64'd0 - longint'(d[i]) : d[i];
			sq += mg * mg;
		end
		theta = int_sqrt(sq);
		x = unit_part(d[0], theta);
		y = unit_part(d[1], theta);
		z = unit_part(d[2], theta);
		tq = theta << 32;
		k = tq / HALF_PI;
		r = tq % HALF_PI;
		fold = (2 * r) > HALF_PI;
		w = fold ? HALF_PI - r : r;
		w = (w + (64'd1 << 28)) >> 29;
		w2 = (w * w) >> 30;
		t = ONE_Q30;
		for (int i = 0; i < 6; i++) t = ONE_Q30 - ((w2 * t) >> 30) / sdv[i];
		s = (w * t) >> 30;
		t = ONE_Q30;
		for (int i = 0; i < 6; i++) t = ONE_Q30 - ((w2 * t) >> 30) / cdv[i];
		c = t;
		if (fold) begin
			tmp = s; s = c; c = tmp;
		end
		// quadrant of the reduced angle
		case (k[1:0])
			2'd0: begin sb = s;  ca = c;  end
			2'd1: begin sb = c;  ca = -s; end
			2'd2: begin sb = -s; ca = -c; end
			default: begin sb = -c; ca = s; end
		endcase
		dd = longint'(ONE_Q30) - ca;
		m[0] = ca + qmul(qmul(z, z), dd);
		m[4] = ca + qmul(qmul(y, y), dd);
		m[8] = ca + qmul(qmul(x, x), dd);
		s1 = -qmul(qmul(y, z), dd);
		s2 = qmul(qmul(x, z), dd);
		s3 = -qmul(qmul(x, y), dd);
		a1 = qmul(x, sb);
		a2 = qmul(y, sb);
		a3 = qmul(z, sb);
		m[1] = s1 + a1; m[3] = s1 - a1;
		m[2] = s2 + a2; m[6] = s2 - a2;
		m[5] = s3 + a3; m[7] = s3 - a3;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += (m[3 * j + i] * v[j]) / 64'sd256;
			acc = acc / (64'sd1 << 22);
			case (i)
				0: o.spin_out_x = clamp32(acc);
				1: o.spin_out_y = clamp32(acc);
				default: o.spin_out_z = clamp32(acc);
			endcase
		end
		return o;
	endfunction

	function void note_input(srr_pkg::in_t it);
		rotated_q.push_back(rotate_spin(it));
	endfunction

	function void check_result(srr_pkg::out_t got);
		srr_pkg::out_t exp_o;
		if (rotated_q.size() == 0) begin
			n_errors++;
			if (n_errors <= 10) $display("unexpected result %h", got);
			return;
		end
		exp_o = rotated_q.pop_front();
		if (got !== exp_o) begin
			n_errors++;
			if (n_errors <= 10)
				$display("mismatch: exp x=%h y=%h z=%h l=%b got x=%h y=%h z=%h l=%b",
					exp_o.spin_out_x, exp_o.spin_out_y, exp_o.spin_out_z, exp_o.last_out,
					got.spin_out_x, got.spin_out_y, got.spin_out_z, got.last_out);
		end
	endfunction

	function int pending();
		return rotated_q.size();
	endfunction
endclass

module tb_spin_rodrigues_rotation;
	localparam int IDLE_LIMIT = 5000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic          strobe;
	srr_pkg::in_t  in_data = '0;
	srr_pkg::out_t out_data;

	spin_scoreboard sb = new();
	int unsigned    idle_cycles = 0;

	spin_rodrigues_rotation u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_data(in_data), .strobe(strobe), .out_data(out_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe) sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// one transaction; returns at the falling edge after acceptance
	task automatic send(srr_pkg::in_t it);
		in_data <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_dir();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom)) >>> $urandom_range(1, 31);
			2: return 32'($signed($urandom)) >>> $urandom_range(3, 8);
			3: return '0;
			4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'($signed($urandom)) >>> 4;
		endcase
	endfunction

	function automatic logic [31:0] rand_spin();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom)) >>> $urandom_range(2, 20);
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'($signed($urandom)) >>> 2;
		endcase
	endfunction

	function automatic srr_pkg::in_t make_item(logic [31:0] dx, logic [31:0] dy,
			logic [31:0] dz, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic l);
		srr_pkg::in_t it;
		it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
		it.spin_in_x = sx; it.spin_in_y = sy; it.spin_in_z = sz;
		it.last_spin = l;
		return it;
	endfunction

	initial begin
		srr_pkg::in_t it;
		int           sent;
		bit           drained;
		drained = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero rotation passes the spin through
		send(make_item(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h12345678, 1'b0));
		send(make_item(0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1));
		// smallest nonzero vectors
		send(make_item(1, 0, 0, 32'h20000000, 32'h20000000, 32'h20000000, 1'b0));
		send(make_item(0, 32'hFFFFFFFF, 0, 32'h20000000, 0, 0, 1'b0));
		send(make_item(0, 0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
		// largest vectors, all signs
		send(make_item(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0));
		send(make_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
		send(make_item(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1'b0));
		// angles near quadrant boundaries (pi/2, pi, 3pi/2, 2pi in Q4.27)
		send(make_item(32'h0C90FDAA, 0, 0, 32'h20000000, 32'h20000000, 32'h20000000, 1'b0));
		send(make_item(0, 32'h1921FB54, 0, 32'h20000000, 32'h20000000, 32'h20000000, 1'b0));
		send(make_item(0, 0, 32'h25B2F8FE, 32'h20000000, 32'h20000000, 32'h20000000, 1'b1));
		send(make_item(32'hCDE04AB0, 0, 0, 32'h20000000, 32'hE0000000, 32'h20000000, 1'b0));
		// saturating results from large spins along a diagonal
		send(make_item(32'h06000000, 32'h06000000, 32'h06000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0));
		send(make_item(32'hFA000000, 32'h06000000, 32'hFA000000,
			32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b1));
		pause(2);

		sent = 0;
		while (sent < 850) begin
			int burst;
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst; b++) begin
				it = make_item(rand_dir(), rand_dir(), rand_dir(),
					rand_spin(), rand_spin(), rand_spin(), $urandom_range(0, 1));
				send(it);
				sent++;
			end
			if (!drained && sent > 400) begin
				// let the pipeline run dry once
				drained = 1'b1;
				start <= 1'b0;
				while (sb.pending() != 0) @(negedge clk);
			end else if ($urandom_range(0, 3) != 0) begin
				pause($urandom_range(1, 12));
			end
		end
		start <= 1'b0;

		while (sb.pending() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (sb.n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### filelist.f
sv/srr_pkg.sv
sv/srr_item_cell.sv
sv/spin_rodrigues_rotation.sv
verif/tb_spin_rodrigues_rotation.sv
